// ===== rtl/core/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Shared constants, request descriptor and filter arithmetic for the PNG
// scanline unfilter core.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int BYTE_W      = 8;
  localparam int NUM_CH      = 4;
  localparam int PIX_W       = NUM_CH * BYTE_W;
  localparam int CHAN_W      = 3;
  localparam int ROWW_W      = 13;
  localparam int FTYPE_W     = 8;
  localparam int FLT_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH     = CFG_IDX_W'(1);

  localparam logic [FLT_W-1:0] FLT_NONE  = FLT_W'(0);
  localparam logic [FLT_W-1:0] FLT_SUB   = FLT_W'(1);
  localparam logic [FLT_W-1:0] FLT_UP    = FLT_W'(2);
  localparam logic [FLT_W-1:0] FLT_AVG   = FLT_W'(3);
  localparam logic [FLT_W-1:0] FLT_PAETH = FLT_W'(4);

  localparam logic [FTYPE_W-1:0] FTYPE_MAX    = FTYPE_W'(4);
  localparam logic [BYTE_W-1:0]  ALPHA_OPAQUE = BYTE_W'(255);
  localparam logic [CHAN_W-1:0]  CHAN_GRAY_A  = CHAN_W'(2);
  localparam logic [CHAN_W-1:0]  CHAN_MAX     = CHAN_W'(NUM_CH);

  typedef struct packed {
    logic [PIX_W-1:0] samples;
    logic [COL_W-1:0] col;
    logic [FLT_W-1:0] flt;
    logic             bad;
    logic             first_row;
    logic             row_start;
    logic             last;
  } desc_t;

  function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                              input logic [BYTE_W-1:0] b,
                                              input logic [BYTE_W-1:0] c);
    logic signed [BYTE_W+1:0] p;
    logic signed [BYTE_W+1:0] da;
    logic signed [BYTE_W+1:0] db;
    logic signed [BYTE_W+1:0] dc;
    p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
    da = p - $signed({2'b00, a});
    db = p - $signed({2'b00, b});
    dc = p - $signed({2'b00, c});
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    else if (db <= dc) return b;
    else return c;
  endfunction

  function automatic logic [BYTE_W-1:0] rebuild(input logic [FLT_W-1:0]  flt,
                                                input logic [BYTE_W-1:0] x,
                                                input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b,
                                                input logic [BYTE_W-1:0] c);
    logic [BYTE_W:0]   sum;
    logic [BYTE_W-1:0] pred;
    sum = {1'b0, a} + {1'b0, b};
    unique case (flt)
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = sum[BYTE_W:1];
      FLT_PAETH: pred = paeth(a, b, c);
      default:   pred = '0;
    endcase
    return x + pred;
  endfunction

endpackage

// ===== rtl/core/psu_pix_if.sv =====
// ----------------------------------------------------------------------------
// psu_pix_if
// Filtered pixel request channel: valid/ready plus one pixel of samples.
// ----------------------------------------------------------------------------
interface psu_pix_if;
  import psu_pkg::*;

  logic               valid;
  logic               ready;
  logic               image_start;
  logic [FTYPE_W-1:0] filter_type;
  logic [BYTE_W-1:0]  sample0;
  logic [BYTE_W-1:0]  sample1;
  logic [BYTE_W-1:0]  sample2;
  logic [BYTE_W-1:0]  sample3;

  modport source (output valid, image_start, filter_type, sample0, sample1, sample2,
                  sample3, input ready);
  modport sink (input valid, image_start, filter_type, sample0, sample1, sample2,
                sample3, output ready);
endinterface

// ===== rtl/core/psu_argb_if.sv =====
// ----------------------------------------------------------------------------
// psu_argb_if
// Reconstructed pixel channel: valid/ready plus one ARGB pixel and flags.
// ----------------------------------------------------------------------------
interface psu_argb_if;
  import psu_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] alpha_out;
  logic [BYTE_W-1:0] red_out;
  logic [BYTE_W-1:0] green_out;
  logic [BYTE_W-1:0] blue_out;
  logic              bad_filter;
  logic              row_end;

  modport source (output valid, alpha_out, red_out, green_out, blue_out, bad_filter,
                  row_end, input ready);
  modport sink (input valid, alpha_out, red_out, green_out, blue_out, bad_filter,
                row_end, output ready);
endinterface

// ===== rtl/core/psu_cfg_if.sv =====
// ----------------------------------------------------------------------------
// psu_cfg_if
// Configuration write channel: valid/ready, register index and write data.
// ----------------------------------------------------------------------------
interface psu_cfg_if;
  import psu_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/png_scanline_unfilter_core.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core
// PNG row filter reconstruction (None/Sub/Up/Average/Paeth), 8-bit samples,
// 1 to 4 channels per pixel, ARGB result per pixel.
//
//   port     dir   handshake     payload
//   in_px    in    valid/ready   image_start, filter_type, sample0..3
//   out_px   out   valid/ready   alpha/red/green/blue_out, bad_filter, row_end
//   cfg_wr   in    valid/ready   index, data (0 channel_count, 1 row_width)
//
// One pixel per clock sustained while the output is not stalled; a pixel passes
// the queue, the line store read and the output register in turn.
// The line store read in the back end sets the pace: one read, one write a cycle.
// Reset clears the control state; the line store holds no reset value.
// A stalled output holds the back end; the four-deep queue accepts until full.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_core (
  input  logic       clk,
  input  logic       rst_n,
  psu_pix_if.sink    in_px,
  psu_argb_if.source out_px,
  psu_cfg_if.sink    cfg_wr
);
  import psu_pkg::*;

  logic [CHAN_W-1:0] chans_r;
  logic [ROWW_W-1:0] width_r;
  logic [CHAN_W-1:0] chans_eff;
  logic [COL_W-1:0]  width_m1;

  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  desc_t             push_desc;
  desc_t             head;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chans_r <= CHAN_MAX;
      width_r <= ROWW_W'(1);
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_CHANNEL_COUNT: chans_r <= cfg_wr.data[CHAN_W-1:0];
        REG_ROW_WIDTH:     width_r <= cfg_wr.data[ROWW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (chans_r == '0) begin
      chans_eff = CHAN_W'(1);
    end else if (chans_r > CHAN_MAX) begin
      chans_eff = CHAN_MAX;
    end else begin
      chans_eff = chans_r;
    end

    if (width_r == '0) begin
      width_m1 = '0;
    end else if (width_r > ROWW_W'(MAX_WIDTH)) begin
      width_m1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_m1 = COL_W'(width_r - ROWW_W'(1));
    end
  end

  psu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_px      (in_px),
    .width_m1   (width_m1),
    .queue_full (q_full),
    .push       (push),
    .desc       (push_desc)
  );

  psu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  psu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .chans       (chans_eff),
    .queue_empty (q_empty),
    .head        (head),
    .pop         (pop),
    .out_px      (out_px)
  );

endmodule

// ===== rtl/core/psu_ram.sv =====
// ----------------------------------------------------------------------------
// psu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/psu_front.sv =====
// ----------------------------------------------------------------------------
// psu_front
// Accepts pixel requests, tracks column, row filter and first-row state, and
// queues a classified descriptor for the back end.
// ----------------------------------------------------------------------------
module psu_front (
  input  logic                   clk,
  input  logic                   rst_n,
  psu_pix_if.sink                in_px,
  input  logic [psu_pkg::COL_W-1:0] width_m1,
  input  logic                   queue_full,
  output logic                   push,
  output psu_pkg::desc_t         desc
);
  import psu_pkg::*;

  logic [COL_W-1:0] col_r,   col_nxt;
  logic             first_r, first_nxt;
  logic [FLT_W-1:0] flt_r,   flt_nxt;
  logic             bad_r,   bad_nxt;

  logic [COL_W-1:0] col;
  logic             first;
  logic             row_start;
  logic             last;

  assign in_px.ready = !queue_full;
  assign push        = in_px.valid && !queue_full;

  always_comb begin
    col       = in_px.image_start ? '0 : col_r;
    first     = in_px.image_start ? 1'b1 : first_r;
    row_start = (col == '0);
    last      = (col >= width_m1);

    if (row_start) begin
      bad_nxt = (in_px.filter_type > FTYPE_MAX);
      flt_nxt = bad_nxt ? FLT_NONE : in_px.filter_type[FLT_W-1:0];
    end else begin
      bad_nxt = bad_r;
      flt_nxt = flt_r;
    end

    if (last) begin
      col_nxt   = '0;
      first_nxt = 1'b0;
    end else begin
      col_nxt   = col + COL_W'(1);
      first_nxt = first;
    end

    desc.samples   = {in_px.sample3, in_px.sample2, in_px.sample1, in_px.sample0};
    desc.col       = col;
    desc.flt       = flt_nxt;
    desc.bad       = bad_nxt;
    desc.first_row = first;
    desc.row_start = row_start;
    desc.last      = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      first_r <= 1'b1;
      flt_r   <= FLT_NONE;
      bad_r   <= 1'b0;
    end else if (push) begin
      col_r   <= col_nxt;
      first_r <= first_nxt;
      flt_r   <= flt_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

// ===== rtl/core/psu_queue.sv =====
// ----------------------------------------------------------------------------
// psu_queue
// Short descriptor FIFO between front and back end.
// ----------------------------------------------------------------------------
module psu_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  psu_pkg::desc_t push_desc,
  input  logic           pop,
  output psu_pkg::desc_t head,
  output logic           full,
  output logic           empty
);
  import psu_pkg::*;

  desc_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]    count_r,  count_nxt;

  assign head  = mem_r[rd_ptr_r];
  assign full  = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/psu_back.sv =====
// ----------------------------------------------------------------------------
// psu_back
// Reads the row above from the line store, rebuilds each channel byte with
// the row filter, writes the line store and presents the ARGB result.
// ----------------------------------------------------------------------------
module psu_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [psu_pkg::CHAN_W-1:0] chans,
  input  logic                       queue_empty,
  input  psu_pkg::desc_t             head,
  output logic                       pop,
  psu_argb_if.source                 out_px
);
  import psu_pkg::*;

  logic              adv;
  logic              we;
  logic              b2_valid_r;
  desc_t             b2_r;
  logic              fwd_r;
  logic [PIX_W-1:0]  fwd_data_r;
  logic [PIX_W-1:0]  left_r;
  logic [PIX_W-1:0]  ul_r;
  logic [PIX_W-1:0]  ram_rdata;
  logic [PIX_W-1:0]  above;
  logic [PIX_W-1:0]  left_px;
  logic [PIX_W-1:0]  ul_px;
  logic [PIX_W-1:0]  recon;

  logic              out_valid_r;
  logic [BYTE_W-1:0] alpha_r, red_r, green_r, blue_r;
  logic              bad_r, row_end_r;
  logic [BYTE_W-1:0] alpha_nxt, red_nxt, green_nxt, blue_nxt;

  assign adv = !out_valid_r || out_px.ready;
  assign pop = adv && !queue_empty;
  assign we  = adv && b2_valid_r;

  psu_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (we),
    .waddr (b2_r.col),
    .wdata (recon),
    .re    (pop),
    .raddr (head.col),
    .rdata (ram_rdata)
  );

  always_comb begin
    above   = b2_r.first_row ? '0 : (fwd_r ? fwd_data_r : ram_rdata);
    left_px = b2_r.row_start ? '0 : left_r;
    ul_px   = b2_r.row_start ? '0 : ul_r;
    for (int k = 0; k < NUM_CH; k++) begin
      if (CHAN_W'(k) < chans) begin
        recon[k*BYTE_W +: BYTE_W] = rebuild(b2_r.flt, b2_r.samples[k*BYTE_W +: BYTE_W],
                                            left_px[k*BYTE_W +: BYTE_W],
                                            above[k*BYTE_W +: BYTE_W],
                                            ul_px[k*BYTE_W +: BYTE_W]);
      end else begin
        recon[k*BYTE_W +: BYTE_W] = '0;
      end
    end

    if (chans <= CHAN_GRAY_A) begin
      alpha_nxt = (chans == CHAN_GRAY_A) ? recon[BYTE_W +: BYTE_W] : ALPHA_OPAQUE;
      red_nxt   = recon[0 +: BYTE_W];
      green_nxt = recon[0 +: BYTE_W];
      blue_nxt  = recon[0 +: BYTE_W];
    end else begin
      alpha_nxt = (chans == CHAN_MAX) ? recon[3*BYTE_W +: BYTE_W] : ALPHA_OPAQUE;
      red_nxt   = recon[0 +: BYTE_W];
      green_nxt = recon[BYTE_W +: BYTE_W];
      blue_nxt  = recon[2*BYTE_W +: BYTE_W];
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      ul_r        <= '0;
    end else if (adv) begin
      b2_valid_r  <= pop;
      out_valid_r <= b2_valid_r;
      if (b2_valid_r) begin
        left_r <= recon;
        ul_r   <= above;
      end
    end
  end

  // payload; same-address write/read in one cycle is bypassed
  always_ff @(posedge clk) begin
    if (pop) begin
      b2_r       <= head;
      fwd_r      <= we && (b2_r.col == head.col);
      fwd_data_r <= recon;
    end
    if (we) begin
      alpha_r   <= alpha_nxt;
      red_r     <= red_nxt;
      green_r   <= green_nxt;
      blue_r    <= blue_nxt;
      bad_r     <= b2_r.bad;
      row_end_r <= b2_r.last;
    end
  end

  assign out_px.valid      = out_valid_r;
  assign out_px.alpha_out  = alpha_r;
  assign out_px.red_out    = red_r;
  assign out_px.green_out  = green_r;
  assign out_px.blue_out   = blue_r;
  assign out_px.bad_filter = bad_r;
  assign out_px.row_end    = row_end_r;

endmodule

// ===== tb/tb_png_scanline_unfilter_core.sv =====
// ----------------------------------------------------------------------------
// tb_png_scanline_unfilter_core
// Self-checking bench for the PNG scanline unfilter core. Filtered pixel
// requests come from a queue; a built-in scanline model keeps its own line
// store, left and upper-left pixels and predicts each ARGB result. Results are
// checked in order, field by field, across several channel counts and row
// widths, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_png_scanline_unfilter_core;
  import psu_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic                    image_start;
    logic [FTYPE_W-1:0]      filter_type;
    logic [3:0][BYTE_W-1:0]  smp;
  } pix_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              bad;
    logic              row_end;
  } argb_t;

  typedef struct packed {
    int chans;
    int width;
    int items;
    int gap_pct;
    int stall_pct;
  } phase_t;

  logic clk;
  logic rst_n;

  psu_pix_if  in_px();
  psu_argb_if out_px();
  psu_cfg_if  cfg_wr();

  png_scanline_unfilter_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_px),
    .out_px (out_px),
    .cfg_wr (cfg_wr)
  );

  always #4 clk = ~clk;

  pix_req_t pending_px[$];
  argb_t    argb_expect[$];
  pix_req_t cur_req;
  int       src_gap_pct;
  int       sink_stall_pct;
  int       mismatches;
  int       idle_cycles;

  // scanline model state
  logic [PIX_W-1:0] line_above [MAX_WIDTH];
  logic [PIX_W-1:0] left_px;
  logic [PIX_W-1:0] upleft_px;
  int               col_cnt;
  logic [FTYPE_W-1:0] row_ftype;
  logic             first_row;
  logic [CHAN_W-1:0] cfg_chans;
  logic [ROWW_W-1:0] cfg_width;

  // request generator's view of row position and line store contents
  int   trk_col;
  logic trk_first;
  bit   stored [MAX_WIDTH];

  logic [FLT_W-1:0] flt_codes [5] = '{FLT_NONE, FLT_SUB, FLT_UP, FLT_AVG, FLT_PAETH};

  function automatic int eff_chans();
    if (cfg_chans == 0) return 1;
    if (cfg_chans > CHAN_MAX) return NUM_CH;
    return int'(cfg_chans);
  endfunction

  function automatic int eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
    return int'(cfg_width);
  endfunction

  function automatic logic [BYTE_W-1:0] paeth_pick(input int a, input int b, input int c);
    int est, da, db, dc;
    est = a + b - c;
    da = (est > a) ? est - a : a - est;
    db = (est > b) ? est - b : b - est;
    dc = (est > c) ? est - c : c - est;
    if (da <= db && da <= dc) return BYTE_W'(a);
    if (db <= dc) return BYTE_W'(b);
    return BYTE_W'(c);
  endfunction

  function automatic logic [BYTE_W-1:0] undo_filter(input logic [FLT_W-1:0] f,
                                                    input logic [BYTE_W-1:0] x,
                                                    input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b,
                                                    input logic [BYTE_W-1:0] c);
    int pred;
    case (f)
      FLT_SUB:   pred = int'(a);
      FLT_UP:    pred = int'(b);
      FLT_AVG:   pred = (int'(a) + int'(b)) / 2;
      FLT_PAETH: pred = int'(paeth_pick(int'(a), int'(b), int'(c)));
      default:   pred = 0;
    endcase
    return BYTE_W'(int'(x) + pred);
  endfunction

  function automatic argb_t unfilter_pixel(input pix_req_t p);
    int                 chans, width, col;
    logic [PIX_W-1:0]   above, recon;
    logic [3:0][BYTE_W-1:0] ch;
    logic               last;
    argb_t              r;
    chans = eff_chans();
    width = eff_width();
    if (p.image_start) begin
      col_cnt = 0;
      first_row = 1'b1;
    end
    if (col_cnt == 0) begin
      row_ftype = p.filter_type;
      left_px = '0;
      upleft_px = '0;
    end
    col = (col_cnt >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_cnt;
    above = first_row ? '0 : line_above[col];
    for (int k = 0; k < NUM_CH; k++) begin
      if (k >= chans) ch[k] = '0;
      else if (row_ftype > FTYPE_MAX) ch[k] = p.smp[k];
      else ch[k] = undo_filter(row_ftype[FLT_W-1:0], p.smp[k], left_px[k*BYTE_W +: BYTE_W],
                               above[k*BYTE_W +: BYTE_W], upleft_px[k*BYTE_W +: BYTE_W]);
      recon[k*BYTE_W +: BYTE_W] = ch[k];
    end
    line_above[col] = recon;
    left_px = recon;
    upleft_px = above;
    last = (col_cnt >= width - 1);
    if (last) begin
      col_cnt = 0;
      first_row = 1'b0;
    end else begin
      col_cnt++;
    end
    if (chans <= CHAN_GRAY_A) begin
      r.alpha = (chans == CHAN_GRAY_A) ? ch[1] : ALPHA_OPAQUE;
      r.red   = ch[0];
      r.green = ch[0];
      r.blue  = ch[0];
    end else begin
      r.alpha = (chans == CHAN_MAX) ? ch[3] : ALPHA_OPAQUE;
      r.red   = ch[0];
      r.green = ch[1];
      r.blue  = ch[2];
    end
    r.bad = (row_ftype > FTYPE_MAX);
    r.row_end = last;
    return r;
  endfunction

  function automatic logic [FTYPE_W-1:0] pick_filter();
    if ($urandom_range(0, 9) == 0) return FTYPE_W'($urandom_range(FTYPE_MAX + 1, 255));
    return FTYPE_W'(flt_codes[$urandom_range(0, 4)]);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // restarts the image where a row would read a line store entry never written
  task automatic queue_pixel(input pix_req_t p);
    if (p.image_start) begin
      trk_col = 0;
      trk_first = 1'b1;
    end
    if (!trk_first && !stored[trk_col]) begin
      p.image_start = 1'b1;
      p.filter_type = pick_filter();
      trk_col = 0;
      trk_first = 1'b1;
    end
    stored[trk_col] = 1'b1;
    if (trk_col >= eff_width() - 1) begin
      trk_col = 0;
      trk_first = 1'b0;
    end else begin
      trk_col++;
    end
    pending_px.push_back(p);
  endtask

  task automatic queue_rows(input int n);
    pix_req_t p;
    for (int i = 0; i < n; i++) begin
      if (trk_col == 0) begin
        p.image_start = ($urandom_range(0, 9) == 0);
        p.filter_type = pick_filter();
      end else begin
        p.image_start = ($urandom_range(0, 49) == 0);
        p.filter_type = p.image_start ? pick_filter() : FTYPE_W'($urandom);
      end
      for (int k = 0; k < NUM_CH; k++) p.smp[k] = rand_byte();
      queue_pixel(p);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
    if (idx == REG_CHANNEL_COUNT) cfg_chans = CHAN_W'(val);
    else if (idx == REG_ROW_WIDTH) cfg_width = ROWW_W'(val);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pending_px.size() != 0 || in_px.valid || argb_expect.size() != 0);
  endtask

  // request driver and scanline prediction on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_px.valid <= 1'b0;
    end else begin
      if (in_px.valid && in_px.ready) argb_expect.push_back(unfilter_pixel(cur_req));
      if (!in_px.valid || in_px.ready) begin
        if (pending_px.size() != 0 && $urandom_range(0, 99) >= src_gap_pct) begin
          cur_req = pending_px.pop_front();
          in_px.valid       <= 1'b1;
          in_px.image_start <= cur_req.image_start;
          in_px.filter_type <= cur_req.filter_type;
          in_px.sample0     <= cur_req.smp[0];
          in_px.sample1     <= cur_req.smp[1];
          in_px.sample2     <= cur_req.smp[2];
          in_px.sample3     <= cur_req.smp[3];
        end else begin
          in_px.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_pixel();
    argb_t exp_px;
    if (argb_expect.size() == 0) begin
      $error("unexpected result: no request outstanding");
      mismatches++;
      return;
    end
    exp_px = argb_expect.pop_front();
    if (out_px.alpha_out !== exp_px.alpha) begin
      $error("alpha_out: expected %0d, got %0d", exp_px.alpha, out_px.alpha_out);
      mismatches++;
    end
    if (out_px.red_out !== exp_px.red) begin
      $error("red_out: expected %0d, got %0d", exp_px.red, out_px.red_out);
      mismatches++;
    end
    if (out_px.green_out !== exp_px.green) begin
      $error("green_out: expected %0d, got %0d", exp_px.green, out_px.green_out);
      mismatches++;
    end
    if (out_px.blue_out !== exp_px.blue) begin
      $error("blue_out: expected %0d, got %0d", exp_px.blue, out_px.blue_out);
      mismatches++;
    end
    if (out_px.bad_filter !== exp_px.bad) begin
      $error("bad_filter: expected %0d, got %0d", exp_px.bad, out_px.bad_filter);
      mismatches++;
    end
    if (out_px.row_end !== exp_px.row_end) begin
      $error("row_end: expected %0d, got %0d", exp_px.row_end, out_px.row_end);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_px.ready <= 1'b0;
    end else begin
      if (out_px.valid && out_px.ready) check_pixel();
      out_px.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_px.valid && in_px.ready) || (out_px.valid && out_px.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  phase_t plan [10] = '{
    '{1, 5, 80, 0, 0},
    '{2, 17, 80, 64, 0},
    '{3, 0, 50, 0, 64},
    '{0, 8, 70, 37, 37},
    '{5, 33, 80, 64, 0},
    '{7, 8191, 30, 0, 64},
    '{4, 6, 80, 37, 37},
    '{6, 4096, 25, 0, 0},
    '{4, 2, 80, 64, 0},
    '{3, 12, 100, 0, 0}
  };

  initial begin
    pix_req_t p;
    clk = 1'b0;
    rst_n = 1'b0;
    in_px.valid = 1'b0;
    in_px.image_start = 1'b0;
    in_px.filter_type = '0;
    in_px.sample0 = '0;
    in_px.sample1 = '0;
    in_px.sample2 = '0;
    in_px.sample3 = '0;
    out_px.ready = 1'b0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = '0;
    cfg_wr.data = '0;
    src_gap_pct = 0;
    sink_stall_pct = 0;
    mismatches = 0;
    idle_cycles = 0;
    left_px = '0;
    upleft_px = '0;
    col_cnt = 0;
    row_ftype = '0;
    first_row = 1'b1;
    cfg_chans = CHAN_W'(4);
    cfg_width = ROWW_W'(1);
    trk_col = 0;
    trk_first = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one-pixel rows, four channels
    @(negedge clk);
    p = '{image_start: 1'b1, filter_type: FTYPE_W'(FLT_SUB), smp: '1};
    queue_pixel(p);
    p = '{image_start: 1'b0, filter_type: FTYPE_W'(FLT_PAETH), smp: '0};
    queue_pixel(p);
    wait_idle();

    // every filter and two bad types, 3-pixel rows, extremes then random samples
    write_reg(REG_CHANNEL_COUNT, 4);
    write_reg(REG_ROW_WIDTH, 3);
    @(negedge clk);
    for (int f = 0; f < 7; f++) begin
      for (int i = 0; i < 3; i++) begin
        p.image_start = (f == 0 && i == 0);
        if (f < 5) p.filter_type = FTYPE_W'(flt_codes[f]);
        else if (f == 5) p.filter_type = FTYPE_W'(FTYPE_MAX + 1);
        else p.filter_type = '1;
        for (int k = 0; k < NUM_CH; k++)
          p.smp[k] = (i == 0) ? '1 : (i == 1) ? '0 : rand_byte();
        queue_pixel(p);
      end
    end
    wait_idle();

    foreach (plan[i]) begin
      src_gap_pct = plan[i].gap_pct;
      sink_stall_pct = plan[i].stall_pct;
      write_reg(REG_CHANNEL_COUNT, ($urandom_range(0, 1023) << CHAN_W) | plan[i].chans);
      write_reg(REG_ROW_WIDTH, plan[i].width);
      @(negedge clk);
      queue_rows(plan[i].items);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && argb_expect.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
